/* rtl/fpsd_pkg.sv */
// Shared types and constants for the fused-estimate PID split drive.
// No dependencies; every other file uses it by scoped names.
package fpsd_pkg;

	localparam int TEMP_W  = 16;
	localparam int COEF_W  = 32;
	localparam int ACC_W   = 64;
	localparam int DEV_W   = 17;
	localparam int EST_W   = 32;
	localparam int ERR_W   = 17;
	localparam int IDX_W   = 3;
	localparam int DRIVE_LIMIT_DEF = 255;

	// estimator constants, Q.24
	localparam logic signed [COEF_W-1:0] EST1_B = 32'sd40802;
	localparam logic signed [COEF_W-1:0] EST1_P = 32'sd16653065;
	localparam logic signed [COEF_W-1:0] EST2_B = 32'sd153646;
	localparam logic signed [COEF_W-1:0] EST2_P = 32'sd16441672;

	typedef enum logic [IDX_W-1:0] {
		REG_SETPOINT   = 3'd0,
		REG_ERR_NOW    = 3'd1,
		REG_ERR_PREV   = 3'd2,
		REG_ERR_PREV2  = 3'd3,
		REG_DRV_PREV   = 3'd4,
		REG_DRV_PREV2  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] setpoint;
		logic signed [COEF_W-1:0] err_now;
		logic signed [COEF_W-1:0] err_prev;
		logic signed [COEF_W-1:0] err_prev2;
		logic signed [COEF_W-1:0] drv_prev;
		logic signed [COEF_W-1:0] drv_prev2;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic clear;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE, S_ISSUE, S_WAIT, S_EST, S_FUSE, S_FIN, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_E1_DEV, OP_E1_Y, OP_E2_DEV, OP_E2_Y,
		OP_D_PREV, OP_D_PREV2, OP_E_NOW, OP_E_PREV, OP_E_PREV2
	} op_t;

endpackage

/* rtl/fpsd_if.sv */
// Valid/ready channel interfaces for sample input and drive result.
// Depends on fpsd_pkg for field widths.
interface fpsd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [fpsd_pkg::TEMP_W-1:0]  temp_first;
	logic signed [fpsd_pkg::TEMP_W-1:0]  temp_second;
	logic signed [fpsd_pkg::TEMP_W-1:0]  temp_third;
	logic                                capture_baseline;
	modport source (output valid, temp_first, temp_second, temp_third, capture_baseline,
		input ready);
	modport sink (input valid, temp_first, temp_second, temp_third, capture_baseline,
		output ready);
endinterface

interface fpsd_out_if;
	logic                                valid;
	logic                                ready;
	logic [7:0]                          heat_duty;
	logic [7:0]                          cool_duty;
	logic signed [8:0]                   drive;
	logic signed [fpsd_pkg::TEMP_W-1:0]  fused_estimate;
	logic signed [fpsd_pkg::ERR_W-1:0]   error_value;
	modport source (output valid, heat_duty, cool_duty, drive, fused_estimate, error_value,
		input ready);
	modport sink (input valid, heat_duty, cool_duty, drive, fused_estimate, error_value,
		output ready);
endinterface

/* rtl/fpsd_cfg.sv */
// Configuration register bank: setpoint and difference-equation weights.
// Depends on fpsd_pkg.
module fpsd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [fpsd_pkg::IDX_W-1:0]          index,
	input  logic [fpsd_pkg::COEF_W-1:0]         data,
	output fpsd_pkg::cfg_t                      cfg
);
	fpsd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint  <= 16'sd8960;
			cfg_q.err_now   <= 32'sd11907891;
			cfg_q.err_prev  <= -32'sd23311155;
			cfg_q.err_prev2 <= 32'sd11403264;
			cfg_q.drv_prev  <= -32'sd231;
			cfg_q.drv_prev2 <= 32'sd65307;
		end else if (we) begin
			unique case (index)
				fpsd_pkg::REG_SETPOINT:  cfg_q.setpoint  <= data[fpsd_pkg::TEMP_W-1:0];
				fpsd_pkg::REG_ERR_NOW:   cfg_q.err_now   <= data;
				fpsd_pkg::REG_ERR_PREV:  cfg_q.err_prev  <= data;
				fpsd_pkg::REG_ERR_PREV2: cfg_q.err_prev2 <= data;
				fpsd_pkg::REG_DRV_PREV:  cfg_q.drv_prev  <= data;
				fpsd_pkg::REG_DRV_PREV2: cfg_q.drv_prev2 <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

/* rtl/fpsd_smac.sv */
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// Depends on fpsd_pkg for widths and the control struct.
module fpsd_smac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpsd_pkg::mac_ctl_t                  ctl,
	input  logic signed [fpsd_pkg::ACC_W-1:0]   mcand,
	input  logic signed [fpsd_pkg::COEF_W-1:0]  mplier,
	output logic                                busy,
	output logic signed [fpsd_pkg::ACC_W-1:0]   acc
);
	localparam int CNT_W = $clog2(fpsd_pkg::COEF_W);

	logic signed [fpsd_pkg::ACC_W-1:0]  a_q;
	logic [fpsd_pkg::COEF_W-1:0]        b_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic                               busy_q;
	logic signed [fpsd_pkg::ACC_W-1:0]  acc_q;
	logic signed [fpsd_pkg::ACC_W-1:0]  pp;
	logic                               last;

	assign pp   = b_q[0] ? a_q : '0;
	assign last = (cnt_q == CNT_W'(fpsd_pkg::COEF_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			if (ctl.clear)
				acc_q <= '0;
		end else if (busy_q) begin
			// the sign bit of the multiplier carries negative weight
			acc_q <= last ? acc_q - pp : acc_q + pp;
			cnt_q <= cnt_q + CNT_W'(1);
			if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= mcand;
			b_q <= mplier;
		end else if (busy_q) begin
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;
endmodule

/* rtl/fused_estimate_pid_split_drive.sv */
// Top level of the fused-estimate PID split drive: sequencer, state and output.
// Depends on fpsd_pkg, fpsd_if, fpsd_cfg and fpsd_smac.
//
// Usage: samples arrive on in_ch (valid/ready); one result per sample leaves on
// out_ch. in_ch.ready is high while the sequencer is idle, one sample at a time.
// A capture sample stores the baselines and returns an all-zero result. An
// ordinary sample runs nine multiply-accumulates on one bit-serial MAC, each a
// load, the multiplier bits in turn and a check that the MAC has finished, plus
// two rounding steps, fusion and finish; the serial MAC sets the throughput, as
// the next sample is taken only once the sequencer is back in idle.
// The result sits in an output register; the next sample is accepted while it
// waits, and a finished result waits in the sequencer until out_ch takes the
// previous one. Configuration writes (cfg_we, cfg_index, cfg_data) belong in
// idle periods; indexes past the last register are ignored.
// Reset (arst_n low) restores default weights and setpoint, clears baselines,
// estimator and controller history, and drops any pending result.
module fused_estimate_pid_split_drive #(
	parameter int DRIVE_LIMIT = fpsd_pkg::DRIVE_LIMIT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fpsd_in_if.sink                        in_ch,
	fpsd_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [fpsd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [fpsd_pkg::COEF_W-1:0]    cfg_data
);
	localparam int ACC_W = fpsd_pkg::ACC_W;
	localparam int DH_W  = $clog2(DRIVE_LIMIT + 1) + 17;
	localparam logic signed [ACC_W-1:0] LIM = ACC_W'(DRIVE_LIMIT) <<< 32;
	localparam logic signed [ACC_W-1:0] DLIM = ACC_W'(DRIVE_LIMIT) <<< 16;

	fpsd_pkg::cfg_t     cfg;
	fpsd_pkg::mac_ctl_t mac_ctl;
	fpsd_pkg::state_t   state_q, state_d;
	fpsd_pkg::op_t      op_q;

	logic                               mac_busy;
	logic signed [ACC_W-1:0]            acc;
	logic signed [ACC_W-1:0]            mcand;
	logic signed [fpsd_pkg::COEF_W-1:0] mplier;

	logic signed [15:0]           base1_q, base2_q, base3_q;
	logic signed [fpsd_pkg::DEV_W-1:0] dev1_q, dev2_q, dev1p_q, dev2p_q;
	logic signed [fpsd_pkg::EST_W-1:0] y1_q, y2_q;
	logic signed [fpsd_pkg::ERR_W-1:0] eh0_q, eh1_q, err_q;
	logic signed [DH_W-1:0]            dh0_q, dh1_q;
	logic signed [15:0]                fused_q;

	logic [7:0]                   r_heat_q, r_cool_q;
	logic signed [8:0]            r_drive_q;
	logic signed [15:0]           r_fused_q;
	logic signed [fpsd_pkg::ERR_W-1:0] r_err_q;
	logic                         out_valid_q;

	logic in_acc, out_load;

	fpsd_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .we(cfg_we), .index(cfg_index), .data(cfg_data),
		.cfg(cfg)
	);

	fpsd_smac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mac_ctl), .mcand(mcand), .mplier(mplier),
		.busy(mac_busy), .acc(acc)
	);

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == fpsd_pkg::S_IDLE);
	assign out_load = (state_q == fpsd_pkg::S_DONE) && (!out_valid_q || out_ch.ready);

	// operand select for the current product
	always_comb begin
		unique case (op_q)
			fpsd_pkg::OP_E1_DEV: begin
				mplier = fpsd_pkg::EST1_B;
				mcand  = ACC_W'(18'(dev1_q) + 18'(dev1p_q)) <<< 8;
			end
			fpsd_pkg::OP_E1_Y: begin
				mplier = fpsd_pkg::EST1_P;
				mcand  = ACC_W'(y1_q);
			end
			fpsd_pkg::OP_E2_DEV: begin
				mplier = fpsd_pkg::EST2_B;
				mcand  = ACC_W'(18'(dev2_q) + 18'(dev2p_q)) <<< 8;
			end
			fpsd_pkg::OP_E2_Y: begin
				mplier = fpsd_pkg::EST2_P;
				mcand  = ACC_W'(y2_q);
			end
			fpsd_pkg::OP_D_PREV: begin
				mplier = cfg.drv_prev;
				mcand  = ACC_W'(dh0_q);
			end
			fpsd_pkg::OP_D_PREV2: begin
				mplier = cfg.drv_prev2;
				mcand  = ACC_W'(dh1_q);
			end
			fpsd_pkg::OP_E_NOW: begin
				mplier = cfg.err_now;
				mcand  = ACC_W'(err_q) <<< 8;
			end
			fpsd_pkg::OP_E_PREV: begin
				mplier = cfg.err_prev;
				mcand  = ACC_W'(eh0_q) <<< 8;
			end
			fpsd_pkg::OP_E_PREV2: begin
				mplier = cfg.err_prev2;
				mcand  = ACC_W'(eh1_q) <<< 8;
			end
			default: begin
				mplier = '0;
				mcand  = '0;
			end
		endcase
	end

	always_comb begin
		mac_ctl.start = (state_q == fpsd_pkg::S_ISSUE);
		mac_ctl.clear = (op_q == fpsd_pkg::OP_E1_DEV) || (op_q == fpsd_pkg::OP_E2_DEV)
			|| (op_q == fpsd_pkg::OP_D_PREV);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpsd_pkg::S_IDLE:
				if (in_acc)
					state_d = in_ch.capture_baseline ? fpsd_pkg::S_DONE : fpsd_pkg::S_ISSUE;
			fpsd_pkg::S_ISSUE: state_d = fpsd_pkg::S_WAIT;
			fpsd_pkg::S_WAIT:
				if (!mac_busy) begin
					priority case (op_q)
						fpsd_pkg::OP_E1_Y, fpsd_pkg::OP_E2_Y: state_d = fpsd_pkg::S_EST;
						fpsd_pkg::OP_E_PREV2: state_d = fpsd_pkg::S_FIN;
						default: state_d = fpsd_pkg::S_ISSUE;
					endcase
				end
			fpsd_pkg::S_EST:
				state_d = (op_q == fpsd_pkg::OP_E2_Y) ? fpsd_pkg::S_FUSE : fpsd_pkg::S_ISSUE;
			fpsd_pkg::S_FUSE: state_d = fpsd_pkg::S_ISSUE;
			fpsd_pkg::S_FIN:  state_d = fpsd_pkg::S_DONE;
			fpsd_pkg::S_DONE:
				if (out_load)
					state_d = fpsd_pkg::S_IDLE;
			default: state_d = fpsd_pkg::S_IDLE;
		endcase
	end

	// rounding, fusion and finish arithmetic
	logic signed [ACC_W-1:0] y_rnd, y_sat;
	logic signed [33:0]      fsum;
	logic signed [24:0]      fsh;
	logic signed [15:0]      fused_d;
	logic signed [ACC_W-1:0] acc_c, d64, whole64;
	logic signed [DH_W-1:0]  d_new;

	always_comb begin
		y_rnd = (acc + (ACC_W'(1) <<< 23)) >>> 24;
		if (y_rnd > ACC_W'(32'sh7fffffff))
			y_sat = ACC_W'(32'sh7fffffff);
		else if (y_rnd < -(ACC_W'(1) <<< 31))
			y_sat = -(ACC_W'(1) <<< 31);
		else
			y_sat = y_rnd;

		fsum = (34'(base3_q) <<< 9) + 34'(y1_q) + 34'(y2_q) + 34'sd256;
		fsh  = 25'(fsum >>> 9);
		if (fsh > 25'sd32767)
			fused_d = 16'sh7fff;
		else if (fsh < -25'sd32768)
			fused_d = 16'sh8000;
		else
			fused_d = 16'(fsh);

		if (acc > LIM)
			acc_c = LIM;
		else if (acc < -LIM)
			acc_c = -LIM;
		else
			acc_c = acc;
		d64   = (acc_c + (ACC_W'(1) <<< 15)) >>> 16;
		d_new = DH_W'(d64);
		if (d64 < 0)
			whole64 = -((-d64) >>> 16);
		else
			whole64 = d64 >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpsd_pkg::S_IDLE;
			op_q        <= fpsd_pkg::OP_E1_DEV;
			out_valid_q <= 1'b0;
			base1_q <= '0; base2_q <= '0; base3_q <= '0;
			dev1p_q <= '0; dev2p_q <= '0;
			y1_q    <= '0; y2_q    <= '0;
			eh0_q   <= '0; eh1_q   <= '0;
			dh0_q   <= '0; dh1_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				fpsd_pkg::S_IDLE:
					if (in_acc && in_ch.capture_baseline) begin
						base1_q <= in_ch.temp_first;
						base2_q <= in_ch.temp_second;
						base3_q <= in_ch.temp_third;
						dev1p_q <= '0; dev2p_q <= '0;
						y1_q    <= '0; y2_q    <= '0;
					end else if (in_acc) begin
						op_q <= fpsd_pkg::OP_E1_DEV;
					end
				fpsd_pkg::S_WAIT:
					if (!mac_busy && op_q != fpsd_pkg::OP_E1_Y && op_q != fpsd_pkg::OP_E2_Y
						&& op_q != fpsd_pkg::OP_E_PREV2)
						op_q <= fpsd_pkg::op_t'(op_q + 4'd1);
				fpsd_pkg::S_EST: begin
					// advance past the rounding step
					op_q <= fpsd_pkg::op_t'(op_q + 4'd1);
					if (op_q == fpsd_pkg::OP_E1_Y) begin
						y1_q    <= 32'(y_sat);
						dev1p_q <= dev1_q;
					end else begin
						y2_q    <= 32'(y_sat);
						dev2p_q <= dev2_q;
					end
				end
				fpsd_pkg::S_FIN: begin
					dh1_q <= dh0_q;
					dh0_q <= d_new;
					eh1_q <= eh0_q;
					eh0_q <= err_q;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dev1_q <= 17'(in_ch.temp_first) - 17'(base1_q);
			dev2_q <= 17'(in_ch.temp_second) - 17'(base2_q);
			r_heat_q <= '0; r_cool_q <= '0; r_drive_q <= '0;
			r_fused_q <= '0; r_err_q <= '0;
		end
		if (state_q == fpsd_pkg::S_FUSE) begin
			fused_q <= fused_d;
			err_q   <= 17'(cfg.setpoint) - 17'(fused_d);
		end
		if (state_q == fpsd_pkg::S_FIN) begin
			r_heat_q  <= (d64 > 0) ? whole64[7:0] : 8'd0;
			r_cool_q  <= (d64 > 0) ? 8'd0 : 8'((-whole64));
			r_drive_q <= whole64[8:0];
			r_fused_q <= fused_q;
			r_err_q   <= err_q;
		end
		if (out_load) begin
			out_ch.heat_duty      <= r_heat_q;
			out_ch.cool_duty      <= r_cool_q;
			out_ch.drive          <= r_drive_q;
			out_ch.fused_estimate <= r_fused_q;
			out_ch.error_value    <= r_err_q;
		end
	end

	assign out_ch.valid = out_valid_q;

	a_mac_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_busy |-> state_q == fpsd_pkg::S_WAIT)
		else $error("serial MAC busy outside its wait state");

	a_capture_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.capture_baseline) |=> state_q == fpsd_pkg::S_DONE)
		else $error("capture transaction did not go straight to result");

	a_split_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.heat_duty == 8'd0 || out_ch.cool_duty == 8'd0))
		else $error("heat and cool duty both active");

	a_drive_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(ACC_W'(dh0_q) <= DLIM) && (ACC_W'(dh0_q) >= -DLIM))
		else $error("stored drive outside limit");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpsd_pkg::S_ISSUE) |=> !in_ch.ready)
		else $error("input ready while a product is running");
endmodule
